@@ rtl/detc_pkg.sv @@
// ----------------------------------------------------------------------------
// detc_pkg: shared types and constants of the dual EMA trend classifier
// Widths of price, seed sums and averages, serial divider sizing, the trend
// codes and the configuration register indexes.
// ----------------------------------------------------------------------------
package detc_pkg;

  localparam int PRICE_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int SEED_BITS  = PRICE_BITS + 8;
  localparam int AVG_BITS   = PRICE_BITS + FRAC_BITS;

  localparam int FAST_W     = 7;
  localparam int SLOW_W     = 8;
  localparam int PER_W      = 8;
  localparam int CNT_W      = 8;
  localparam int MAX_PERIOD = 200;

  localparam logic [FAST_W-1:0] FAST_RESET = FAST_W'(9);
  localparam logic [SLOW_W-1:0] SLOW_RESET = SLOW_W'(21);

  // Serial divider: seed mean divides sum * 2^FRAC_BITS, the update divides 2 * |x - avg|
  localparam int DIV_W     = SEED_BITS + FRAC_BITS;
  localparam int UPD_W     = AVG_BITS + 1;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // (f - s) * 2000 built from shifts: 2048 - 32 - 16
  localparam int TR_SH_HI  = 11;
  localparam int TR_SH_MID = 5;
  localparam int TR_SH_LO  = 4;

  // Shared adder/subtractor, wide enough for d * 2048
  localparam int ALU_W = AVG_BITS + TR_SH_HI + 1;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD = CFG_IDX_W'(1);

  localparam int TREND_W = 2;
  typedef enum logic [TREND_W-1:0] {
    TREND_NEUTRAL = 2'd0,
    TREND_UP      = 2'd1,
    TREND_DOWN    = 2'd2
  } trend_t;

endpackage

@@ rtl/dual_ema_trend_classifier.sv @@
// Sequencing: a counted close in the averaging phase runs, per average, a select, the
// subtract forming |x - avg| (a second one when the first borrows), the serial divider and
// a write-back, then the trend compare and the load of the output register. A seeding close
// takes a select and an accumulate per average, plus the divider and a write-back when the
// seed mean is taken. A skipped close goes straight to the trend compare. One transaction
// at a time; the next can be accepted in the cycle after the result is loaded. Sync reset.
// ----------------------------------------------------------------------------
// dual_ema_trend_classifier
// Fast and slow exponential averages of closing prices with trend output,
// computed by a small sequencer around one shared add/subtract unit.
// ----------------------------------------------------------------------------
module dual_ema_trend_classifier
  import detc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,

  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [PRICE_BITS-1:0] in_close_price,
  input  logic                  in_close_valid,
  input  logic                  in_series_start,

  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [TREND_W-1:0]    out_trend,
  output logic                  out_enough_data
);

  typedef enum logic [3:0] {
    S_IDLE, S_SEL, S_ACC, S_DIFF1, S_DIFF2, S_DIV, S_SEED, S_UPD,
    S_TR1, S_TR2, S_TR3, S_TR4, S_TR5, S_OUT
  } state_t;

  state_t                state_r, state_nxt;

  logic [FAST_W-1:0]     fast_period_r, fast_period_nxt;
  logic [SLOW_W-1:0]     slow_period_r, slow_period_nxt;

  logic [CNT_W-1:0]      valid_count_r, valid_count_nxt;
  logic [SEED_BITS-1:0]  fast_sum_r, fast_sum_nxt;
  logic [SEED_BITS-1:0]  slow_sum_r, slow_sum_nxt;
  logic [AVG_BITS-1:0]   fast_avg_r, fast_avg_nxt;
  logic [AVG_BITS-1:0]   slow_avg_r, slow_avg_nxt;

  logic [PRICE_BITS-1:0] price_r, price_nxt;
  logic                  cvalid_r, cvalid_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  sel_r, sel_nxt;     // 0 fast, 1 slow
  logic                  seed_r, seed_nxt;   // divider result is a seed mean
  logic                  up_r, up_nxt;       // close above average
  logic                  neg_r, neg_nxt;     // slow above fast

  logic [DIV_W-1:0]      qd_r, qd_nxt;
  logic [PER_W-1:0]      rem_r, rem_nxt;
  logic [PER_W-1:0]      divisor_r, divisor_nxt;
  logic [DIV_CNT_W-1:0]  div_cnt_r, div_cnt_nxt;

  logic [AVG_BITS-1:0]   d_r, d_nxt;
  logic [ALU_W-1:0]      t_r, t_nxt;
  trend_t                trend_r, trend_nxt;

  logic                  out_valid_r, out_valid_nxt;
  trend_t                out_trend_r, out_trend_nxt;
  logic                  out_enough_r, out_enough_nxt;

  // shared unit
  logic [ALU_W-1:0]      alu_a, alu_b;
  logic                  alu_sub;
  logic [ALU_W:0]        alu_res;
  logic                  alu_borrow;

  logic [PER_W-1:0]      pf, ps, pmax, cur_p;
  logic [SEED_BITS-1:0]  cur_sum;
  logic [AVG_BITS-1:0]   cur_avg;
  logic [AVG_BITS-1:0]   xf;
  logic                  enough;
  logic                  in_fire;
  logic [PER_W:0]        div_trial;

  assign cfg_ready       = 1'b1;
  assign in_ready        = (state_r == S_IDLE);
  assign in_fire         = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_trend       = out_trend_r;
  assign out_enough_data = out_enough_r;

  // Effective periods: zero acts as one, clamp at the maximum
  always_comb begin
    if (fast_period_r == '0) begin
      pf = PER_W'(1);
    end else if (PER_W'(fast_period_r) > PER_W'(MAX_PERIOD)) begin
      pf = PER_W'(MAX_PERIOD);
    end else begin
      pf = PER_W'(fast_period_r);
    end
    if (slow_period_r == '0) begin
      ps = PER_W'(1);
    end else if (PER_W'(slow_period_r) > PER_W'(MAX_PERIOD)) begin
      ps = PER_W'(MAX_PERIOD);
    end else begin
      ps = PER_W'(slow_period_r);
    end
  end

  assign pmax    = (pf > ps) ? pf : ps;
  assign enough  = (PER_W'(valid_count_r) >= pmax);
  assign cur_p   = sel_r ? ps : pf;
  assign cur_sum = sel_r ? slow_sum_r : fast_sum_r;
  assign cur_avg = sel_r ? slow_avg_r : fast_avg_r;
  assign xf      = {price_r, {FRAC_BITS{1'b0}}};
  assign div_trial = {rem_r, qd_r[DIV_W-1]};

  // Operand selection for the shared adder/subtractor
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b1;
    unique case (state_r)
      S_ACC: begin
        alu_a   = ALU_W'(cur_sum);
        alu_b   = ALU_W'(price_r);
        alu_sub = 1'b0;
      end
      S_DIFF1: begin
        alu_a = ALU_W'(xf);
        alu_b = ALU_W'(cur_avg);
      end
      S_DIFF2: begin
        alu_a = ALU_W'(cur_avg);
        alu_b = ALU_W'(xf);
      end
      S_DIV: begin
        alu_a = ALU_W'(div_trial);
        alu_b = ALU_W'(divisor_r);
      end
      S_UPD: begin
        alu_a   = ALU_W'(cur_avg);
        alu_b   = ALU_W'(qd_r[AVG_BITS-1:0]);
        alu_sub = !up_r;
      end
      S_TR1: begin
        alu_a = ALU_W'(fast_avg_r);
        alu_b = ALU_W'(slow_avg_r);
      end
      S_TR2: begin
        alu_a = ALU_W'(slow_avg_r);
        alu_b = ALU_W'(fast_avg_r);
      end
      S_TR3: begin
        alu_a = ALU_W'(d_r) << TR_SH_HI;
        alu_b = ALU_W'(d_r) << TR_SH_MID;
      end
      S_TR4: begin
        alu_a = t_r;
        alu_b = ALU_W'(d_r) << TR_SH_LO;
      end
      S_TR5: begin
        alu_a = ALU_W'(slow_avg_r);
        alu_b = t_r;
      end
      default: begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
      end
    endcase
  end

  assign alu_res    = alu_sub ? ({1'b0, alu_a} - {1'b0, alu_b})
                              : ({1'b0, alu_a} + {1'b0, alu_b});
  assign alu_borrow = alu_res[ALU_W];

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    fast_period_nxt = fast_period_r;
    slow_period_nxt = slow_period_r;
    valid_count_nxt = valid_count_r;
    fast_sum_nxt    = fast_sum_r;
    slow_sum_nxt    = slow_sum_r;
    fast_avg_nxt    = fast_avg_r;
    slow_avg_nxt    = slow_avg_r;
    price_nxt       = price_r;
    cvalid_nxt      = cvalid_r;
    cnt_nxt         = cnt_r;
    sel_nxt         = sel_r;
    seed_nxt        = seed_r;
    up_nxt          = up_r;
    neg_nxt         = neg_r;
    qd_nxt          = qd_r;
    rem_nxt         = rem_r;
    divisor_nxt     = divisor_r;
    div_cnt_nxt     = div_cnt_r;
    d_nxt           = d_r;
    t_nxt           = t_r;
    trend_nxt       = trend_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_trend_nxt   = out_trend_r;
    out_enough_nxt  = out_enough_r;

    if (cfg_valid && cfg_ready) begin
      priority if (cfg_index == CFG_FAST_PERIOD) begin
        fast_period_nxt = cfg_data[FAST_W-1:0];
      end else if (cfg_index == CFG_SLOW_PERIOD) begin
        slow_period_nxt = cfg_data[SLOW_W-1:0];
      end else begin
        fast_period_nxt = fast_period_r;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          price_nxt  = in_close_price;
          cvalid_nxt = in_close_valid;
          sel_nxt    = 1'b0;
          trend_nxt  = TREND_NEUTRAL;
          cnt_nxt    = in_series_start ? '0 : valid_count_r;
          if (in_series_start) begin
            fast_sum_nxt = '0;
            slow_sum_nxt = '0;
            fast_avg_nxt = '0;
            slow_avg_nxt = '0;
          end
          if (in_close_valid && (cnt_nxt != '1)) begin
            valid_count_nxt = cnt_nxt + CNT_W'(1);
          end else begin
            valid_count_nxt = cnt_nxt;
          end
          state_nxt = in_close_valid ? S_SEL : S_TR1;
        end
      end
      S_SEL: begin
        state_nxt = (PER_W'(cnt_r) < cur_p) ? S_ACC : S_DIFF1;
      end
      S_ACC: begin
        if (sel_r) begin
          slow_sum_nxt = alu_res[SEED_BITS-1:0];
        end else begin
          fast_sum_nxt = alu_res[SEED_BITS-1:0];
        end
        if (({1'b0, cnt_r} + (CNT_W+1)'(1)) == (CNT_W+1)'(cur_p)) begin
          // seed mean: floor(sum * 2^FRAC / p)
          qd_nxt      = {alu_res[SEED_BITS-1:0], {FRAC_BITS{1'b0}}};
          rem_nxt     = '0;
          divisor_nxt = cur_p;
          div_cnt_nxt = DIV_CNT_W'(DIV_W);
          seed_nxt    = 1'b1;
          state_nxt   = S_DIV;
        end else begin
          sel_nxt   = 1'b1;
          state_nxt = sel_r ? S_TR1 : S_SEL;
        end
      end
      S_DIFF1, S_DIFF2: begin
        if ((state_r == S_DIFF1) && alu_borrow) begin
          state_nxt = S_DIFF2;
        end else begin
          // 2 * |x - avg| left-aligned in the dividend
          qd_nxt      = {alu_res[AVG_BITS-1:0], {(DIV_W-AVG_BITS){1'b0}}};
          rem_nxt     = '0;
          divisor_nxt = cur_p + PER_W'(1);
          div_cnt_nxt = DIV_CNT_W'(UPD_W);
          seed_nxt    = 1'b0;
          up_nxt      = (state_r == S_DIFF1);
          state_nxt   = S_DIV;
        end
      end
      S_DIV: begin
        // restoring division, one quotient bit a cycle; remainder stays below the divisor
        rem_nxt     = alu_borrow ? div_trial[PER_W-1:0] : alu_res[PER_W-1:0];
        qd_nxt      = {qd_r[DIV_W-2:0], !alu_borrow};
        div_cnt_nxt = div_cnt_r - DIV_CNT_W'(1);
        if (div_cnt_r == DIV_CNT_W'(1)) begin
          state_nxt = seed_r ? S_SEED : S_UPD;
        end
      end
      S_SEED, S_UPD: begin
        if (sel_r) begin
          slow_avg_nxt = (state_r == S_SEED) ? qd_r[AVG_BITS-1:0] : alu_res[AVG_BITS-1:0];
        end else begin
          fast_avg_nxt = (state_r == S_SEED) ? qd_r[AVG_BITS-1:0] : alu_res[AVG_BITS-1:0];
        end
        sel_nxt   = 1'b1;
        state_nxt = sel_r ? S_TR1 : S_SEL;
      end
      S_TR1: begin
        if (!enough) begin
          trend_nxt = TREND_NEUTRAL;
          state_nxt = S_OUT;
        end else begin
          neg_nxt   = alu_borrow;
          d_nxt     = alu_res[AVG_BITS-1:0];
          state_nxt = alu_borrow ? S_TR2 : S_TR3;
        end
      end
      S_TR2: begin
        d_nxt     = alu_res[AVG_BITS-1:0];
        state_nxt = S_TR3;
      end
      S_TR3, S_TR4: begin
        t_nxt     = alu_res[ALU_W-1:0];
        state_nxt = (state_r == S_TR3) ? S_TR4 : S_TR5;
      end
      S_TR5: begin
        // borrow means d * 2000 > slow
        if (alu_borrow) begin
          trend_nxt = neg_r ? TREND_DOWN : TREND_UP;
        end else begin
          trend_nxt = TREND_NEUTRAL;
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_trend_nxt  = trend_r;
          out_enough_nxt = enough;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      fast_period_r <= FAST_RESET;
      slow_period_r <= SLOW_RESET;
      valid_count_r <= '0;
      fast_sum_r    <= '0;
      slow_sum_r    <= '0;
      fast_avg_r    <= '0;
      slow_avg_r    <= '0;
      out_valid_r   <= 1'b0;
      sel_r         <= 1'b0;
      seed_r        <= 1'b0;
      div_cnt_r     <= '0;
    end else begin
      state_r       <= state_nxt;
      fast_period_r <= fast_period_nxt;
      slow_period_r <= slow_period_nxt;
      valid_count_r <= valid_count_nxt;
      fast_sum_r    <= fast_sum_nxt;
      slow_sum_r    <= slow_sum_nxt;
      fast_avg_r    <= fast_avg_nxt;
      slow_avg_r    <= slow_avg_nxt;
      out_valid_r   <= out_valid_nxt;
      sel_r         <= sel_nxt;
      seed_r        <= seed_nxt;
      div_cnt_r     <= div_cnt_nxt;
    end
    price_r      <= price_nxt;
    cvalid_r     <= cvalid_nxt;
    cnt_r        <= cnt_nxt;
    up_r         <= up_nxt;
    neg_r        <= neg_nxt;
    qd_r         <= qd_nxt;
    rem_r        <= rem_nxt;
    divisor_r    <= divisor_nxt;
    d_r          <= d_nxt;
    t_r          <= t_nxt;
    trend_r      <= trend_nxt;
    out_trend_r  <= out_trend_nxt;
    out_enough_r <= out_enough_nxt;
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_trend_needs_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_trend == TREND_NEUTRAL || out_enough_data))
    else $error("trend reported before enough data");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("input taken while a transaction is in progress");

  a_div_count_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (div_cnt_r != '0))
    else $error("divider running with zero step count");

  a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && div_cnt_r == DIV_CNT_W'(1)) |=>
      (state_r == S_SEED || state_r == S_UPD))
    else $error("divider did not hand over its quotient");

  // a series restart clears the count even on a skipped close
  a_skip_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_TR1 && !cvalid_r && $past(state_r) == S_IDLE &&
     !$past(in_series_start)) |-> $stable(valid_count_r))
    else $error("skipped close changed the count");

endmodule
